>>> hw/rtl/rptn_pkg.sv
// ----------------------------------------------------------------------------
// RGB patch token normalizer package
// Shared widths, codes, reset values and types of the normalizer.
// ----------------------------------------------------------------------------
package rptn_pkg;

    localparam int PIX_W      = 8;
    localparam int VAL_W      = 24;
    localparam int IDX_W      = 22;
    localparam int PW_W       = 11;
    localparam int PS_W       = 7;
    localparam int PC_W       = 10;
    localparam int PR_W       = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int PROD_W     = PIX_W + 1 + VAL_W;
    localparam int AREA3_W    = 16;
    localparam int ROFF_W     = 14;

    localparam int PW_CAP        = 1024;
    localparam int PATCH_ROW_CAP = 2047;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATCHES_WIDE = 3'd0,
        CFG_PATCH_SIZE   = 3'd1,
        CFG_GAIN_RED     = 3'd2,
        CFG_GAIN_GREEN   = 3'd3,
        CFG_GAIN_BLUE    = 3'd4,
        CFG_OFFSET_RED   = 3'd5,
        CFG_OFFSET_GREEN = 3'd6,
        CFG_OFFSET_BLUE  = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_WIDE = 2'd1,
        ST_TALL = 2'd2
    } t_status;

    localparam logic [PW_W-1:0]         RST_PATCHES_WIDE = 11'd14;
    localparam logic [PS_W-1:0]         RST_PATCH_SIZE   = 7'd16;
    localparam logic signed [VAL_W-1:0] RST_GAIN_RED     = 24'sd68497;
    localparam logic signed [VAL_W-1:0] RST_GAIN_GREEN   = 24'sd70006;
    localparam logic signed [VAL_W-1:0] RST_GAIN_BLUE    = 24'sd69693;
    localparam logic signed [VAL_W-1:0] RST_OFFSET_RED   = -24'sd139171;
    localparam logic signed [VAL_W-1:0] RST_OFFSET_GREEN = -24'sd133234;
    localparam logic signed [VAL_W-1:0] RST_OFFSET_BLUE  = -24'sd118283;

    // Position of one pixel inside the patch grid.
    typedef struct packed {
        logic [PR_W-1:0] patch_row;
        logic [PS_W-1:0] row_in_patch;
        logic [PC_W-1:0] patch_column;
        logic [PS_W-1:0] column_in_patch;
    } t_pos;

    // Geometry derived from the configuration registers.
    typedef struct packed {
        logic [PW_W-1:0] pw_eff;
        logic [PS_W-1:0] ps_eff;
        logic            wide;
    } t_geom;

endpackage

>>> hw/rtl/rptn_pix_if.sv
// ----------------------------------------------------------------------------
// Pixel channel
// Valid/ready channel that carries one RGB pixel and its frame start flag.
// ----------------------------------------------------------------------------
interface rptn_pix_if import rptn_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             frame_start;

    modport source (output valid, output red, output green, output blue,
                    output frame_start, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input frame_start, output ready);
endinterface

>>> hw/rtl/rptn_res_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries three normalized values, the token buffer
// index of the red value and a status code.
// ----------------------------------------------------------------------------
interface rptn_res_if import rptn_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] value_red;
    logic signed [VAL_W-1:0] value_green;
    logic signed [VAL_W-1:0] value_blue;
    logic [IDX_W-1:0]        red_index;
    t_status                 status;

    modport source (output valid, output value_red, output value_green,
                    output value_blue, output red_index, output status, input ready);
    modport sink   (input valid, input value_red, input value_green,
                    input value_blue, input red_index, input status, output ready);
endinterface

>>> hw/rtl/rptn_channel.sv
// ----------------------------------------------------------------------------
// Channel normalizer
// Three stage multiply, round, offset and saturate datapath of one color.
// ----------------------------------------------------------------------------
module rptn_channel import rptn_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [PIX_W-1:0]        i_pixel,
    input  logic signed [VAL_W-1:0] i_gain,
    input  logic signed [VAL_W-1:0] i_offset,
    input  logic                    i_err,
    output logic signed [VAL_W-1:0] o_value
);

    localparam logic signed [PROD_W-1:0] SAT_HI   = PROD_W'(2**(VAL_W-1) - 1);
    localparam logic signed [PROD_W-1:0] SAT_LO   = -PROD_W'(2**(VAL_W-1));
    localparam logic signed [PROD_W-1:0] ROUND_CT = PROD_W'(8);

    logic [PIX_W-1:0]         r_pixel;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] n_prod;
    logic signed [VAL_W-1:0]  r_value;
    logic signed [VAL_W-1:0]  n_value;
    logic signed [PROD_W-1:0] biased;
    logic signed [PROD_W-1:0] shifted;
    logic signed [PROD_W-1:0] sum;

    assign n_prod = $signed({1'b0, r_pixel}) * i_gain;

    always_comb begin
        biased  = r_prod + ROUND_CT;
        shifted = biased >>> 4;
        sum     = shifted + PROD_W'(i_offset);
        if (i_err) begin
            n_value = '0;
        end else if (sum > SAT_HI) begin
            n_value = SAT_HI[VAL_W-1:0];
        end else if (sum < SAT_LO) begin
            n_value = SAT_LO[VAL_W-1:0];
        end else begin
            n_value = sum[VAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pixel <= i_pixel;
            r_prod  <= n_prod;
            r_value <= n_value;
        end
    end

    assign o_value = r_value;

endmodule

>>> hw/rtl/rptn_position.sv
// ----------------------------------------------------------------------------
// Patch position tracker
// Raster position counters and the three stage token index and status path.
// ----------------------------------------------------------------------------
module rptn_position import rptn_pkg::*; #(
    parameter int MAX_HEIGHT = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_accept,
    input  logic             i_frame_start,
    input  t_geom            i_geom,
    output logic             o_err,
    output logic [IDX_W-1:0] o_red_index,
    output t_status          o_status
);

    localparam int ROW_W = PR_W + PS_W + 1;

    t_pos               r_pos;
    t_pos               n_pos;
    t_pos               cur;
    t_pos               r_a;
    logic [PS_W:0]      col_inc;
    logic [PC_W:0]      pc_inc;
    logic [PS_W:0]      rip_inc;
    logic [ROW_W-1:0]   pix_row;
    logic [AREA3_W-1:0] area;
    logic [IDX_W-1:0]   n_token;
    logic [AREA3_W-1:0] n_area3;
    logic [ROFF_W-1:0]  n_roff;
    t_status            n_status;
    logic [IDX_W-1:0]   r_token;
    logic [AREA3_W-1:0] r_area3;
    logic [ROFF_W-1:0]  r_roff;
    t_status            r_status_b;
    logic [IDX_W-1:0]   idx;
    logic [IDX_W-1:0]   r_index;
    t_status            r_status_c;

    always_comb begin
        cur     = i_frame_start ? '0 : r_pos;
        n_pos   = cur;
        col_inc = {1'b0, cur.column_in_patch} + 1'b1;
        pc_inc  = {1'b0, cur.patch_column} + 1'b1;
        rip_inc = {1'b0, cur.row_in_patch} + 1'b1;
        if (col_inc >= {1'b0, i_geom.ps_eff}) begin
            n_pos.column_in_patch = '0;
            if (PW_W'(pc_inc) >= i_geom.pw_eff) begin
                n_pos.patch_column = '0;
                if (rip_inc >= {1'b0, i_geom.ps_eff}) begin
                    n_pos.row_in_patch = '0;
                    if (cur.patch_row < PR_W'(PATCH_ROW_CAP)) begin
                        n_pos.patch_row = cur.patch_row + 1'b1;
                    end
                end else begin
                    n_pos.row_in_patch = rip_inc[PS_W-1:0];
                end
            end else begin
                n_pos.patch_column = pc_inc[PC_W-1:0];
            end
        end else begin
            n_pos.column_in_patch = col_inc[PS_W-1:0];
        end
    end

    always_comb begin
        pix_row = ROW_W'(r_a.patch_row) * ROW_W'(i_geom.ps_eff)
                + ROW_W'(r_a.row_in_patch);
        n_token = IDX_W'(r_a.patch_row) * IDX_W'(i_geom.pw_eff)
                + IDX_W'(r_a.patch_column);
        area    = AREA3_W'(i_geom.ps_eff) * AREA3_W'(i_geom.ps_eff);
        n_area3 = area + (area << 1);
        n_roff  = ROFF_W'(r_a.row_in_patch) * ROFF_W'(i_geom.ps_eff)
                + ROFF_W'(r_a.column_in_patch);
        if (i_geom.wide) begin
            n_status = ST_WIDE;
        end else if (int'(pix_row) >= MAX_HEIGHT) begin
            n_status = ST_TALL;
        end else begin
            n_status = ST_OK;
        end
    end

    assign idx   = r_token * IDX_W'(r_area3) + IDX_W'(r_roff);
    assign o_err = (r_status_b != ST_OK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_accept) begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a        <= cur;
            r_token    <= n_token;
            r_area3    <= n_area3;
            r_roff     <= n_roff;
            r_status_b <= n_status;
            r_index    <= o_err ? '0 : idx;
            r_status_c <= r_status_b;
        end
    end

    assign o_red_index = r_index;
    assign o_status    = r_status_c;

endmodule

>>> hw/rtl/rgb_patch_token_normalizer.sv
// ----------------------------------------------------------------------------
// RGB patch token normalizer
// Normalizes raster RGB pixels and places them in a patch token buffer.
// ----------------------------------------------------------------------------
// One pixel beat is taken in every cycle while the pipeline is not stalled;
// the rate is set by the raster position counters, which advance once
// per accepted beat, while the multipliers sit in a three stage pipeline that
// stalls as a whole only when the result register is full and not taken.
// Each channel computes x * gain + offset with the product rounded half up to
// Q8.16 and the sum saturated to 24 bits. A beat with frame_start restarts
// the position counters. Frames that are too wide or too tall report their
// status with zeroed values and index.
module rgb_patch_token_normalizer import rptn_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_PATCH  = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    rptn_pix_if.sink              i_pix,
    rptn_res_if.source            o_res
);

    logic [PW_W-1:0]         r_patches_wide;
    logic [PS_W-1:0]         r_patch_size;
    logic signed [VAL_W-1:0] r_gain_red;
    logic signed [VAL_W-1:0] r_gain_green;
    logic signed [VAL_W-1:0] r_gain_blue;
    logic signed [VAL_W-1:0] r_offset_red;
    logic signed [VAL_W-1:0] r_offset_green;
    logic signed [VAL_W-1:0] r_offset_blue;
    logic                    r_va;
    logic                    r_vb;
    logic                    r_vc;
    logic                    en;
    logic                    accept;
    logic                    err;
    logic [PW_W-1:0]         pw_nz;
    t_geom                   geom;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_patches_wide <= RST_PATCHES_WIDE;
            r_patch_size   <= RST_PATCH_SIZE;
            r_gain_red     <= RST_GAIN_RED;
            r_gain_green   <= RST_GAIN_GREEN;
            r_gain_blue    <= RST_GAIN_BLUE;
            r_offset_red   <= RST_OFFSET_RED;
            r_offset_green <= RST_OFFSET_GREEN;
            r_offset_blue  <= RST_OFFSET_BLUE;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_PATCHES_WIDE: r_patches_wide <= i_cfg_data[PW_W-1:0];
                CFG_PATCH_SIZE:   r_patch_size   <= i_cfg_data[PS_W-1:0];
                CFG_GAIN_RED:     r_gain_red     <= i_cfg_data;
                CFG_GAIN_GREEN:   r_gain_green   <= i_cfg_data;
                CFG_GAIN_BLUE:    r_gain_blue    <= i_cfg_data;
                CFG_OFFSET_RED:   r_offset_red   <= i_cfg_data;
                CFG_OFFSET_GREEN: r_offset_green <= i_cfg_data;
                CFG_OFFSET_BLUE:  r_offset_blue  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        pw_nz       = (r_patches_wide == '0) ? PW_W'(1) : r_patches_wide;
        geom.pw_eff = (pw_nz > PW_W'(PW_CAP)) ? PW_W'(PW_CAP) : pw_nz;
        if (r_patch_size == '0) begin
            geom.ps_eff = PS_W'(1);
        end else if (int'(r_patch_size) > MAX_PATCH) begin
            geom.ps_eff = PS_W'(MAX_PATCH);
        end else begin
            geom.ps_eff = r_patch_size;
        end
        geom.wide = (pw_nz > PW_W'(PW_CAP))
                 || (int'(pw_nz) * int'(geom.ps_eff) > MAX_WIDTH);
    end

    assign en          = !r_vc || o_res.ready;
    assign accept      = i_pix.valid && en;
    assign i_pix.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else if (en) begin
            r_va <= i_pix.valid;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    rptn_position #(
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_position (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_accept      (accept),
        .i_frame_start (i_pix.frame_start),
        .i_geom        (geom),
        .o_err         (err),
        .o_red_index   (o_res.red_index),
        .o_status      (o_res.status)
    );

    rptn_channel u_red (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_pixel  (i_pix.red),
        .i_gain   (r_gain_red),
        .i_offset (r_offset_red),
        .i_err    (err),
        .o_value  (o_res.value_red)
    );

    rptn_channel u_green (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_pixel  (i_pix.green),
        .i_gain   (r_gain_green),
        .i_offset (r_offset_green),
        .i_err    (err),
        .o_value  (o_res.value_green)
    );

    rptn_channel u_blue (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_pixel  (i_pix.blue),
        .i_gain   (r_gain_blue),
        .i_offset (r_offset_blue),
        .i_err    (err),
        .o_value  (o_res.value_blue)
    );

    assign o_res.valid = r_vc;

endmodule

>>> hw/rtl/rptn_checker.sv
// ----------------------------------------------------------------------------
// Normalizer port checker
// Concurrent checks on the ports of the normalizer, attached by bind.
// ----------------------------------------------------------------------------
module rptn_checker import rptn_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    i_in_ready,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic signed [VAL_W-1:0] i_value_red,
    input logic signed [VAL_W-1:0] i_value_green,
    input logic signed [VAL_W-1:0] i_value_blue,
    input logic [IDX_W-1:0]        i_red_index,
    input t_status                 i_status
);

    // A stalled result beat keeps its index, red value and status.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_red_index)
            && $stable(i_value_red) && $stable(i_status))
        else $error("result beat changed while stalled");

    // A beat in error carries zero values and a zero index.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != ST_OK |-> i_red_index == '0
            && i_value_red == '0 && i_value_green == '0 && i_value_blue == '0)
        else $error("error beat with nonzero payload");

    // An empty result register never holds back the input.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty result register");

    // Without back pressure an accepted beat reaches the output.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) ##1 i_out_ready ##1 i_out_ready |=> i_out_valid)
        else $error("accepted beat did not reach the output");

endmodule

bind rgb_patch_token_normalizer rptn_checker u_rptn_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_pix.valid),
    .i_in_ready    (i_pix.ready),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_value_red   (o_res.value_red),
    .i_value_green (o_res.value_green),
    .i_value_blue  (o_res.value_blue),
    .i_red_index   (o_res.red_index),
    .i_status      (o_res.status)
);
